// ===== rtl/merge_sorter_macros.svh =====
// Assertion macros shared by the merge sorter checker.
`ifndef MERGE_SORTER_MACROS_SVH
`define MERGE_SORTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MSORT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define MSORT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/msort_pkg.sv =====
// Shared types for the merge sorter: cell commands and controller states.
package msort_pkg;

	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_INSERT,
		CMD_SHIFT
	} cmd_t;

	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} state_t;

	// Command that the controller broadcasts to every cell.
	typedef struct packed {
		cmd_t cmd;
	} cell_ctl_t;

endpackage

// ===== rtl/msort_cell.sv =====
// One cell of the sorting chain: holds a key and its valid bit.
module msort_cell #(
	parameter int KEY_BITS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  msort_pkg::cell_ctl_t       ctl,
	input  logic signed [KEY_BITS-1:0] new_key,
	input  logic signed [KEY_BITS-1:0] prev_key,
	input  logic                       prev_valid,
	input  logic                       prev_take,
	input  logic signed [KEY_BITS-1:0] next_key,
	input  logic                       next_valid,
	output logic signed [KEY_BITS-1:0] cell_key,
	output logic                       cell_valid,
	output logic                       take
);
	import msort_pkg::*;

	logic signed [KEY_BITS-1:0] key_q;
	logic                       valid_q;

	// The new word belongs at or ahead of this cell when the cell is empty or
	// holds a strictly larger key; equal keys stay ahead, which keeps order stable.
	assign take       = !valid_q || (new_key < key_q);
	assign cell_key   = key_q;
	assign cell_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (ctl.cmd)
				CMD_INSERT: begin
					if (prev_take) begin
						valid_q <= prev_valid;
					end else if (take) begin
						valid_q <= 1'b1;
					end
				end
				CMD_SHIFT: valid_q <= next_valid;
				default:   valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.cmd)
			CMD_INSERT: begin
				if (prev_take) begin
					key_q <= prev_key;
				end else if (take) begin
					key_q <= new_key;
				end
			end
			CMD_SHIFT: key_q <= next_key;
			default:   key_q <= key_q;
		endcase
	end

endmodule

// ===== rtl/merge_sorter.sv =====
// Top level of the merge sorter: a chain of insertion cells and its controller.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------
//   in      | in_valid / in_ready  | key, last
//   out     | out_valid / out_ready| sorted_key, final_res, dropped
//
// A key is inserted into the chain in the cycle it is accepted; one taken while
// full is lost and sets dropped. in_ready is low while a set is draining.
// The sorted set leaves from the head cell, one word per cycle while out_ready
// is high; the chain shifts toward the head on every accepted output word.
// A stalled output simply holds the chain. Reset empties every cell at once.
// The next set is taken in the cycle after the word flagged final_res leaves.
module merge_sorter #(
	parameter int DEPTH    = 64,
	parameter int KEY_BITS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [KEY_BITS-1:0] key,
	input  logic                       last,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [KEY_BITS-1:0] sorted_key,
	output logic                       final_res,
	output logic                       dropped
);
	import msort_pkg::*;

	state_t    state_q, state_nxt;
	logic      overflow_q;
	cell_ctl_t ctl;
	logic      in_fire, out_fire, full;

	logic signed [KEY_BITS-1:0] key_c   [DEPTH];
	logic                       valid_c [DEPTH];
	logic                       take_c  [DEPTH];

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;
	assign full     = valid_c[DEPTH-1];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [KEY_BITS-1:0] p_key, n_key;
		logic                       p_valid, p_take, n_valid;

		if (i == 0) begin : g_head
			assign p_key   = '0;
			assign p_valid = 1'b0;
			assign p_take  = 1'b0;
		end else begin : g_mid
			assign p_key   = key_c[i-1];
			assign p_valid = valid_c[i-1];
			assign p_take  = take_c[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign n_key   = '0;
			assign n_valid = 1'b0;
		end else begin : g_body
			assign n_key   = key_c[i+1];
			assign n_valid = valid_c[i+1];
		end

		msort_cell #(
			.KEY_BITS(KEY_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.new_key   (key),
			.prev_key  (p_key),
			.prev_valid(p_valid),
			.prev_take (p_take),
			.next_key  (n_key),
			.next_valid(n_valid),
			.cell_key  (key_c[i]),
			.cell_valid(valid_c[i]),
			.take      (take_c[i])
		);
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_LOAD: begin
				if (in_fire && last) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (out_fire && final_res) begin
					state_nxt = ST_LOAD;
				end
			end
			default: state_nxt = ST_LOAD;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		ctl.cmd   = CMD_HOLD;
		case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				if (in_fire && !full) begin
					ctl.cmd = CMD_INSERT;
				end
			end
			ST_DRAIN: begin
				out_valid = valid_c[0];
				if (out_fire) begin
					ctl.cmd = CMD_SHIFT;
				end
			end
			default: ctl.cmd = CMD_HOLD;
		endcase
	end

	assign sorted_key = key_c[0];
	assign final_res  = !valid_c[1];
	assign dropped    = overflow_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			overflow_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (in_fire && full) begin
				overflow_q <= 1'b1;
			end else if (out_fire && final_res) begin
				overflow_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/msort_chk.sv =====
// Port-level checker for the merge sorter, bound to the top level.
`include "merge_sorter_macros.svh"

module msort_chk #(
	parameter int KEY_BITS = 32
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       last,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic signed [KEY_BITS-1:0] sorted_key,
	input logic                       final_res
);

	// A stalled output word must hold.
	`MSORT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sorted_key), "output word changed while stalled")

	// Loading and draining never overlap.
	`MSORT_ASSERT_NOW(a_no_overlap, out_valid, !in_ready, "input ready while draining")

	// Within a set, each word follows directly and is not smaller than the one before.
	`MSORT_ASSERT_NEXT(a_ascending, out_valid && out_ready && !final_res, out_valid && (sorted_key >= $past(sorted_key)), "sorted run broken or out of order")

	// After the final word the block is ready for the next set.
	`MSORT_ASSERT_NEXT(a_reload, out_valid && out_ready && final_res, in_ready && !out_valid, "block not ready after final word")

	// A key flagged last starts the drain at once.
	`MSORT_ASSERT_NEXT(a_drain_start, in_valid && in_ready && last, out_valid && !in_ready, "drain did not start after last key")

endmodule

bind merge_sorter msort_chk #(
	.KEY_BITS(KEY_BITS)
) u_msort_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.last      (last),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.sorted_key(sorted_key),
	.final_res (final_res)
);
